[hdl/bso_pkg.sv]
`default_nettype none

package bso_pkg;

  // Fixed field widths
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  // Samples per buffer; an index equal to the last position advances the offset
  localparam int unsigned BUFFER_LENGTH = 512;
  localparam int unsigned LAST_INDEX    = BUFFER_LENGTH - 1;

  // Digit-serial datapath: DIGIT_W bits per cycle
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned PHASE_DIGITS = PHASE_W / DIGIT_W;
  localparam int unsigned AMP_DIGITS   = (AMP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned AMP_SR_W     = AMP_DIGITS * DIGIT_W;
  localparam int unsigned PSUM_W       = IDX_W + DIGIT_W + 1;
  localparam int unsigned CARRY_W      = PSUM_W - DIGIT_W;
  localparam int unsigned MSUM_W       = AMP_W + DIGIT_W + 1;
  localparam int unsigned ACC_W        = MSUM_W - DIGIT_W;
  localparam int unsigned PROD_W       = ACC_W + AMP_SR_W;
  localparam int unsigned FRAC_W       = 15;
  localparam int unsigned CNT_W        = $clog2(PHASE_DIGITS);

  // Register select: paddr bit 2 picks the word
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic REG_PHASE_INC = 1'b0;
  localparam logic REG_AMPLITUDE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LOOK,
    ST_MUL,
    ST_OUT
  } state_e;

  // pi/2 in Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // (a * b) >> 62, low 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // round(32767 * sin(pi/2 * j / 2^qbits)); elaboration only
  function automatic logic [AMP_W-1:0] quarter_sine(input logic [31:0] j,
                                                    input int unsigned qbits);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    mask = (64'd1 << qbits) - 64'd1;
    x = (HALF_PI_Q62 >> qbits) * {32'd0, j}
      + (((HALF_PI_Q62 & mask) * {32'd0, j}) >> qbits);
    x2 = mul_q62(x, x);
    term = x;
    s = x;
    // Taylor series, odd terms subtract
    term = mul_q62(term, x2) / 64'd6;   s = s - term;
    term = mul_q62(term, x2) / 64'd20;  s = s + term;
    term = mul_q62(term, x2) / 64'd42;  s = s - term;
    term = mul_q62(term, x2) / 64'd72;  s = s + term;
    term = mul_q62(term, x2) / 64'd110; s = s - term;
    term = mul_q62(term, x2) / 64'd156; s = s + term;
    term = mul_q62(term, x2) / 64'd210; s = s - term;
    term = mul_q62(term, x2) / 64'd272; s = s + term;
    term = mul_q62(term, x2) / 64'd342; s = s - term;
    term = mul_q62(term, x2) / 64'd420; s = s + term;
    term = mul_q62(term, x2) / 64'd506; s = s - term;
    term = mul_q62(term, x2) / 64'd600; s = s + term;
    term = mul_q62(term, x2) / 64'd702; s = s - term;
    v = ((s >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[AMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/bso_sine_rom.sv]
`default_nettype none

// Quarter-wave sine ROM, entries 0..2^(TABLE_BITS-2) inclusive, registered read
module bso_sine_rom #(
  parameter int unsigned TABLE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rd_en_i,
  input  wire logic [TABLE_BITS-2:0]           addr_i,
  output logic      [bso_pkg::AMP_W-1:0]       data_o
);

  localparam int unsigned QB    = TABLE_BITS - 2;
  localparam int unsigned QSIZE = 1 << QB;

  logic [bso_pkg::AMP_W-1:0] rom [QSIZE+1];
  logic [bso_pkg::AMP_W-1:0] data_q;

  for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
    localparam logic [bso_pkg::AMP_W-1:0] Entry = bso_pkg::quarter_sine(32'(g), QB);
    assign rom[g] = Entry;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hdl/buffered_sine_oscillator_core.sv]
`default_nettype none

// Channel   Direction  Handshake              Beat contents
// input     in         in_valid_i/in_ready_o  sample_index_i
// output    out        out_valid_o/out_ready_i sample_value_o, buffer_end_o
// config    in         APB psel/penable       phase_increment @0x0, amplitude @0x4
//
// An input beat is taken only in idle; it then passes the phase, lookup,
// gain-multiply and output states, and the next beat is taken once the core
// is back in idle. The 4-bit digit loop runs the phase and the gain multiply.
// The output register holds a result while the sink stalls; a new beat can
// start meanwhile and waits in the last state only if the old one is unread.
// Reset clears both registers, the phase offset and the handshake state.
module buffered_sine_oscillator_core #(
  parameter int unsigned TABLE_BITS = 12
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // sample index channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [bso_pkg::IDX_W-1:0]            sample_index_i,
  // sample channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [bso_pkg::SAMPLE_W-1:0]       sample_value_o,
  output logic                                      buffer_end_o,
  // APB register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [bso_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [bso_pkg::DATA_W-1:0]           pwdata,
  output logic      [bso_pkg::DATA_W-1:0]           prdata,
  output logic                                      pready
);

  localparam int unsigned PW  = bso_pkg::PHASE_W;
  localparam int unsigned DW  = bso_pkg::DIGIT_W;
  localparam int unsigned QB  = TABLE_BITS - 2;
  localparam int unsigned QSIZE = 1 << QB;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [PW-1:0]                phase_inc_q;
  logic [bso_pkg::AMP_W-1:0]    amplitude_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      amplitude_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[bso_pkg::REG_SEL_BIT] == bso_pkg::REG_PHASE_INC) begin
        phase_inc_q <= pwdata;
      end else begin
        amplitude_q <= pwdata[bso_pkg::AMP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[bso_pkg::REG_SEL_BIT] == bso_pkg::REG_AMPLITUDE)
                ? bso_pkg::DATA_W'(amplitude_q) : phase_inc_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  bso_pkg::state_e               state_q, state_d;
  logic [bso_pkg::CNT_W-1:0]     cnt_q;
  logic                          last_phase_digit;
  logic                          last_amp_digit;
  logic                          in_take;
  logic                          out_load;
  logic                          rom_rd;

  assign last_phase_digit = (cnt_q == bso_pkg::CNT_W'(bso_pkg::PHASE_DIGITS - 1));
  assign last_amp_digit   = (cnt_q == bso_pkg::CNT_W'(bso_pkg::AMP_DIGITS - 1));

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    in_take    = 1'b0;
    out_load   = 1'b0;
    rom_rd     = 1'b0;
    case (state_q)
      bso_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_take = 1'b1;
          state_d = bso_pkg::ST_PHASE;
        end
      end
      bso_pkg::ST_PHASE: begin
        if (last_phase_digit) begin
          state_d = bso_pkg::ST_LOOK;
        end
      end
      bso_pkg::ST_LOOK: begin
        rom_rd  = 1'b1;
        state_d = bso_pkg::ST_MUL;
      end
      bso_pkg::ST_MUL: begin
        if (last_amp_digit) begin
          state_d = bso_pkg::ST_OUT;
        end
      end
      bso_pkg::ST_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bso_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bso_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bso_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q != state_d) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase: idx * inc + offset, one digit a cycle, LSB first.
  // On the last index the offset shifts in offset' = phase + inc, i.e.
  // offset + BUFFER_LENGTH * inc; otherwise it just rotates back to itself.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]                   phase_offset_q;
  logic [bso_pkg::IDX_W-1:0]       idx_q;
  logic                            end_q;
  logic [PW-1:0]                   inc_sr_q;
  logic [bso_pkg::CARRY_W-1:0]     carry_q;
  logic                            ocarry_q;
  logic [PW-1:0]                   phase_sr_q;
  logic [bso_pkg::PSUM_W-1:0]      psum;
  logic [DW:0]                     osum;
  logic [DW-1:0]                   off_digit;
  logic                            is_last;

  assign is_last = (32'(sample_index_i) == bso_pkg::LAST_INDEX);

  assign psum = bso_pkg::PSUM_W'(idx_q) * bso_pkg::PSUM_W'(inc_sr_q[DW-1:0])
              + bso_pkg::PSUM_W'(carry_q)
              + bso_pkg::PSUM_W'(phase_offset_q[DW-1:0]);
  assign osum = {1'b0, psum[DW-1:0]} + {1'b0, inc_sr_q[DW-1:0]} + (DW+1)'(ocarry_q);
  assign off_digit = end_q ? osum[DW-1:0] : phase_offset_q[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_offset_q <= '0;
    end else if (state_q == bso_pkg::ST_PHASE) begin
      phase_offset_q <= {off_digit, phase_offset_q[PW-1:DW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      idx_q    <= sample_index_i;
      end_q    <= is_last;
      inc_sr_q <= phase_inc_q;
      carry_q  <= '0;
      ocarry_q <= 1'b0;
    end else if (state_q == bso_pkg::ST_PHASE) begin
      inc_sr_q   <= inc_sr_q >> DW;
      carry_q    <= psum[bso_pkg::PSUM_W-1:DW];
      ocarry_q   <= osum[DW];
      phase_sr_q <= {psum[DW-1:0], phase_sr_q[PW-1:DW]};
    end
  end

  // ---------------------------------------------------------------------------
  // Table lookup: quadrant folds onto the quarter-wave ROM
  // ---------------------------------------------------------------------------
  logic [TABLE_BITS-1:0]          tab_idx;
  logic [QB:0]                    rom_addr;
  logic [bso_pkg::AMP_W-1:0]      rom_data;
  logic                           neg_q;

  assign tab_idx  = phase_sr_q[PW-1 -: TABLE_BITS];
  assign rom_addr = tab_idx[QB] ? ((QB+1)'(QSIZE) - {1'b0, tab_idx[QB-1:0]})
                                : {1'b0, tab_idx[QB-1:0]};

  bso_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (rom_rd),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  // ---------------------------------------------------------------------------
  // Gain: |sine| * amplitude, amplitude digits LSB first
  // ---------------------------------------------------------------------------
  logic [bso_pkg::AMP_SR_W-1:0]   amp_sr_q;
  logic [bso_pkg::ACC_W-1:0]      acc_q;
  logic [bso_pkg::AMP_SR_W-1:0]   low_sr_q;
  logic [bso_pkg::MSUM_W-1:0]     msum;
  logic [bso_pkg::PROD_W-1:0]     prod;
  logic [bso_pkg::SAMPLE_W-1:0]   hi;
  logic [bso_pkg::SAMPLE_W-1:0]   mag;
  logic                           frac_nz;

  assign msum = bso_pkg::MSUM_W'(acc_q)
              + bso_pkg::MSUM_W'(rom_data) * bso_pkg::MSUM_W'(amp_sr_q[DW-1:0]);

  always_ff @(posedge clk_i) begin
    if (rom_rd) begin
      neg_q    <= tab_idx[QB+1];
      amp_sr_q <= bso_pkg::AMP_SR_W'(amplitude_q);
      acc_q    <= '0;
    end else if (state_q == bso_pkg::ST_MUL) begin
      amp_sr_q <= amp_sr_q >> DW;
      acc_q    <= msum[bso_pkg::MSUM_W-1:DW];
      low_sr_q <= {msum[DW-1:0], low_sr_q[bso_pkg::AMP_SR_W-1:DW]};
    end
  end

  // floor(+-p / 2^15): negative side rounds the magnitude up
  assign prod    = {acc_q, low_sr_q};
  assign hi      = prod[bso_pkg::FRAC_W +: bso_pkg::SAMPLE_W];
  assign frac_nz = |prod[bso_pkg::FRAC_W-1:0];
  assign mag     = hi + bso_pkg::SAMPLE_W'(frac_nz);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                           out_valid_q;
  logic [bso_pkg::SAMPLE_W-1:0]   sample_q;
  logic                           buf_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q  <= neg_q ? (~mag + 1'b1) : hi;
      buf_end_q <= end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = signed'(sample_q);
  assign buffer_end_o   = buf_end_q;

endmodule

`default_nettype wire

[tb/sv/sine_check_pkg.sv]
package sine_check_pkg;
  import bso_pkg::*;

  localparam int unsigned LUT_BITS = 12;
  localparam int unsigned QTR_BITS = LUT_BITS - 2;
  // quarter turn (pi/2), Q2.62
  localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] QTR_MASK = (64'd1 << QTR_BITS) - 64'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } sample_t;

  class sine_sample_board;
    int                  sine_lut[1 << LUT_BITS];
    logic [PHASE_W-1:0]  increment;
    logic [AMP_W-1:0]    gain;
    logic [PHASE_W-1:0]  offset;
    sample_t             awaited_samples[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         ends;

    // sine table from a fixed-point Taylor series, one quarter mirrored and negated
    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] v;
      int          j;
      for (int k = 0; k < (1 << LUT_BITS); k++) begin
        j = k % (1 << QTR_BITS);
        if (k[QTR_BITS]) begin
          j = (1 << QTR_BITS) - j;
        end
        x = (QUARTER_TURN_Q62 >> QTR_BITS) * 64'(j)
          + (((QUARTER_TURN_Q62 & QTR_MASK) * 64'(j)) >> QTR_BITS);
        x2 = mul_q62(x, x);
        term = x;
        s = x;
        for (int n = 1; n <= 13; n++) begin
          term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            s = s - term;
          end else begin
            s = s + term;
          end
        end
        v = ((s >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
        if (v > 64'd32767) begin
          v = 64'd32767;
        end
        sine_lut[k] = k[QTR_BITS+1] ? -int'(v) : int'(v);
      end
      increment  = '0;
      gain       = '0;
      offset     = '0;
      mismatches = 0;
      checked    = 0;
      ends       = 0;
    endfunction

    static function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    function void set_register(logic sel, logic [DATA_W-1:0] data);
      if (sel == REG_PHASE_INC) begin
        increment = data;
      end else begin
        gain = data[AMP_W-1:0];
      end
    endfunction

    // phase = idx * inc + offset; last index moves the offset a whole buffer on
    function void note_index(logic [IDX_W-1:0] idx);
      logic [PHASE_W-1:0] phase;
      int                 prod;
      sample_t            s;
      phase = PHASE_W'(idx) * increment + offset;
      prod = sine_lut[phase[PHASE_W-1 -: LUT_BITS]] * int'({1'b0, gain});
      s.value = SAMPLE_W'(prod >>> 15);
      s.last = (idx == LAST_INDEX);
      if (s.last) begin
        offset = offset + PHASE_W'(BUFFER_LENGTH) * increment;
      end
      awaited_samples.push_back(s);
    endfunction

    function int unsigned pending();
      return awaited_samples.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_sample(logic signed [SAMPLE_W-1:0] value, logic last);
      sample_t s;
      if (awaited_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d arrived with none awaited", value));
        return;
      end
      s = awaited_samples.pop_front();
      if (value !== s.value) begin
        report_mismatch($sformatf("beat %0d sample_value %0d, want %0d",
                                  checked, value, s.value));
      end
      if (last !== s.last) begin
        report_mismatch($sformatf("beat %0d buffer_end %0b, want %0b",
                                  checked, last, s.last));
      end
      if (s.last) begin
        ends++;
      end
      checked++;
    endtask
  endclass

endpackage

[tb/sv/tb_top.sv]
module tb_top;
  import bso_pkg::*;
  import sine_check_pkg::*;

  localparam int unsigned ITEMS_TOTAL = 1250;
  // last stretch of the run has no random sink stalls or sender gaps
  localparam int unsigned CALM_TAIL   = 150;
  // settle time before touching registers
  localparam int unsigned SETTLE      = 20;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [IDX_W-1:0]           sample_index_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] sample_value_o;
  logic                       buffer_end_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  sine_sample_board board = new();

  bit          calm;
  int unsigned sent;
  int unsigned settings_used;

  buffered_sine_oscillator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_index_i(sample_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_value_o(sample_value_o),
    .buffer_end_o  (buffer_end_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(4 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end

  // Both channels are sampled at the rising edge, before any of this
  // edge's nonblocking updates land, so the view matches the DUT's.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.note_index(sample_index_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_sample(sample_value_o, buffer_end_o);
      end
    end
  end

  // Sink: random stall bursts between ready stretches; none when calm.
  // Every pass waits at least one edge, so one NBA per time step.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Hold one index beat until it is taken. Returns on the accepting edge;
  // the caller either raises valid again for the next beat or drops it.
  task automatic send_index(logic [IDX_W-1:0] idx);
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sent++;
    // tail of the run starts mid-sequence too
    if (sent + CALM_TAIL >= ITEMS_TOTAL) begin
      calm = 1'b1;
    end
  endtask

  // Occasional sender idle burst.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every sample owed has come back, then let
  // the core settle. The first wait moves past the edge that took the last
  // beat, so the scoreboard has already noted it.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup, then access; lands on the edge with pready high.
  // The bus goes idle afterwards, keeping back-to-back writes on separate steps.
  task automatic write_reg(logic sel, logic [DATA_W-1:0] data);
    logic [ADDR_W-1:0] addr;
    addr = '0;
    addr[REG_SEL_BIT] = sel;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(sel, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [PHASE_W-1:0] inc, logic [AMP_W-1:0] amp);
    write_reg(REG_PHASE_INC, inc);
    write_reg(REG_AMPLITUDE, DATA_W'(amp));
    settings_used++;
  endtask

  task automatic send_each(int idx_list[$]);
    foreach (idx_list[i]) begin
      sender_gap();
      send_index(idx_list[i][IDX_W-1:0]);
    end
  endtask

  initial begin
    int unsigned      quota;
    int unsigned      phase_start;
    int unsigned      len;
    int unsigned      first;
    logic [PHASE_W-1:0] inc;
    logic [AMP_W-1:0] amp;

    calm           = 1'b0;
    sent           = 0;
    settings_used  = 0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    sample_index_i <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // Registers at reset: zero gain and increment, all samples zero; the
    // last index still flags the buffer end.
    send_each('{0, 511, 300});

    // 1/512 turn per index at full scale: zero crossings, positive peak
    // at 128, negative peak at 384; a full buffer adds exactly one turn.
    drain();
    configure(32'h0080_0000, 15'd32767);
    send_each('{0, 128, 256, 384, 511, 1, 510, 383, 129});

    // Largest increment, smallest nonzero gain: results only 0 or -1,
    // offset wraps on each buffer end.
    drain();
    configure(32'hFFFF_FFFF, 15'd1);
    send_each('{511, 1, 255, 256, 0, 511});

    // Irregular even increment, half gain, alternating index bits.
    drain();
    configure(32'h1234_5678, 15'd16384);
    send_each('{170, 341, 511, 17});

    // --- random part ---
    // Register settings change only between phases, after a full drain.
    // Within a phase most traffic is buffer tails that run up to the last
    // index, so the offset keeps advancing; the rest is loose indices and
    // runs that stop short of the end.
    while (sent < ITEMS_TOTAL) begin
      drain();
      case ($urandom_range(0, 5))
        0:       inc = '0;
        1:       inc = 32'hFFFF_FFFF;
        2:       inc = PHASE_W'($urandom_range(1, 4096));
        3:       inc = PHASE_W'(1) << $urandom_range(0, 31);
        default: inc = PHASE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       amp = '0;
        1:       amp = 15'd32767;
        default: amp = AMP_W'($urandom_range(0, 32767));
      endcase
      configure(inc, amp);

      quota       = $urandom_range(120, 220);
      phase_start = sent;
      while (sent - phase_start < quota && sent < ITEMS_TOTAL) begin
        calm = (sent + CALM_TAIL >= ITEMS_TOTAL);
        case ($urandom_range(0, 15))
          0, 1: begin
            // loose indices
            repeat ($urandom_range(1, 4)) begin
              sender_gap();
              send_index(IDX_W'($urandom_range(0, 511)));
            end
          end
          2, 3: begin
            // run that stops short of the buffer end
            first = $urandom_range(0, 500);
            len   = $urandom_range(1, 40);
            for (int i = first; i < first + len && i < LAST_INDEX && sent < ITEMS_TOTAL;
                 i++) begin
              sender_gap();
              send_index(IDX_W'(i));
            end
          end
          4: begin
            // pressure: hold off until the core has returned everything
            if (!calm) begin
              drain();
            end
          end
          5: begin
            // occasionally a whole buffer, otherwise a longer tail
            len = ($urandom_range(0, 7) == 0) ? BUFFER_LENGTH : $urandom_range(49, 96);
            for (int i = BUFFER_LENGTH - len; i < BUFFER_LENGTH && sent < ITEMS_TOTAL;
                 i++) begin
              sender_gap();
              send_index(IDX_W'(i));
            end
          end
          default: begin
            // buffer tail ending on the last index
            len = $urandom_range(1, 48);
            for (int i = BUFFER_LENGTH - len; i < BUFFER_LENGTH && sent < ITEMS_TOTAL;
                 i++) begin
              sender_gap();
              send_index(IDX_W'(i));
            end
          end
        endcase
      end
    end

    calm = 1'b1;
    drain();

    $display("Checked %0d samples over %0d register settings, %0d buffer ends.",
             board.checked, settings_used, board.ends);
    $display("Index beats sent: %0d, mismatches: %0d.", sent, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[buffered_sine_oscillator_core.f]
hdl/bso_pkg.sv
hdl/bso_sine_rom.sv
hdl/buffered_sine_oscillator_core.sv
tb/sv/sine_check_pkg.sv
tb/sv/tb_top.sv
